### sv/ibms_pkg.sv
// shared types, widths and codes for the interval best-match scorer
`timescale 1ns / 1ps
package ibms_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int OP_W    = 2;
   localparam int CHROM_W = 8;
   localparam int POS_W   = 32;
   localparam int SUM_W   = POS_W + 1;
   localparam int TAG_W   = 24;
   localparam int ZYG_W   = 4;
   localparam int TOL_W   = 24;
   localparam int INDEX_W = 10;
   localparam int SCORE_W = 6;

   // stream widths
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 1;

   // op codes on the request side
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // scoring constants
   localparam logic [15:0]        BO_PREFIX  = 16'h426F;
   localparam logic [SCORE_W-1:0] REL_EXACT  = 6'd4;
   localparam logic [SCORE_W-1:0] REL_COVRD  = 6'd3;
   localparam logic [SCORE_W-1:0] REL_COVER  = 6'd2;
   localparam logic [SCORE_W-1:0] REL_OVLP   = 6'd1;
   localparam logic [SCORE_W-1:0] BONUS_TAG  = 6'd20;
   localparam logic [SCORE_W-1:0] BONUS_ZYG  = 6'd10;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_QUERY,
      CMD_CLEAR
   } cmd_kind_type;

   // one interval with positions already in ascending order
   typedef struct packed {
      logic [CHROM_W-1:0] chrom;
      logic [POS_W-1:0]   lo;
      logic [POS_W-1:0]   hi;
      logic [TAG_W-1:0]   tag;
      logic [ZYG_W-1:0]   zyg;
   } entry_type;

   typedef struct packed {
      cmd_kind_type kind;
      entry_type    ent;
   } cmd_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } back_state_type;

endpackage

### sv/ibms_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module ibms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/ibms_front.sv
// front end: unpacks request items, orders positions and classifies the op
`timescale 1ns / 1ps
module ibms_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ibms_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [ibms_pkg::OP_W-1:0]        req_tuser,
   input  logic                             q_ready,
   output logic                             q_push,
   output ibms_pkg::cmd_type                q_cmd
);

   logic [ibms_pkg::CHROM_W-1:0] chrom;
   logic [ibms_pkg::POS_W-1:0]   pos_a;
   logic [ibms_pkg::POS_W-1:0]   pos_b;
   logic [ibms_pkg::TAG_W-1:0]   tag;
   logic [ibms_pkg::ZYG_W-1:0]   zyg;
   logic                         op_known;
   logic                         swap;

   // unpack fields from the lowest bit up
   assign chrom = req_tdata[7:0];
   assign pos_a = req_tdata[39:8];
   assign pos_b = req_tdata[71:40];
   assign tag   = req_tdata[95:72];
   assign zyg   = req_tdata[99:96];

   // put each interval in ascending order once, on the way in
   assign swap = pos_a > pos_b;

   always_comb begin
      q_cmd.ent.chrom = chrom;
      q_cmd.ent.lo    = swap ? pos_b : pos_a;
      q_cmd.ent.hi    = swap ? pos_a : pos_b;
      q_cmd.ent.tag   = tag;
      q_cmd.ent.zyg   = zyg;
      q_cmd.kind      = ibms_pkg::CMD_LOAD;
      op_known        = 1'b1;
      // op decode, unknown op is accepted and dropped
      unique case (req_tuser)
         ibms_pkg::OP_LOAD:  q_cmd.kind = ibms_pkg::CMD_LOAD;
         ibms_pkg::OP_QUERY: q_cmd.kind = ibms_pkg::CMD_QUERY;
         ibms_pkg::OP_CLEAR: q_cmd.kind = ibms_pkg::CMD_CLEAR;
         default:            op_known   = 1'b0;
      endcase
   end

   assign req_tready = q_ready;
   assign q_push     = req_tvalid & q_ready & op_known;

endmodule

### sv/ibms_cmd_queue.sv
// short command queue between front end and back end
`timescale 1ns / 1ps
module ibms_cmd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ibms_pkg::cmd_type        push_cmd,
   output logic                     ready,
   input  logic                     pop,
   output ibms_pkg::queue_head_type head
);

   ibms_pkg::cmd_type               slot_ff [ibms_pkg::QUEUE_DEPTH];
   logic [ibms_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ibms_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ibms_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                            do_push;
   logic                            do_pop;

   assign ready   = cnt_ff != ibms_pkg::QCNT_W'(ibms_pkg::QUEUE_DEPTH);
   assign do_push = push & ready;
   assign do_pop  = pop & (cnt_ff != '0);

   assign head.valid = cnt_ff != '0;
   assign head.cmd   = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ibms_pkg::QPTR_W'(ibms_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ibms_pkg::QPTR_W'(ibms_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/ibms_back.sv
// back end: reference table, entry scan, scoring pipeline and result register
`timescale 1ns / 1ps
module ibms_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ibms_pkg::TOL_W-1:0]       csr_wdata,
   input  ibms_pkg::queue_head_type         q_head,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ibms_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [ibms_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   ibms_pkg::back_state_type        state_ff, state_in;
   logic [ibms_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [ibms_pkg::IDX_W-1:0]      addr_ff, addr_in;
   logic [ibms_pkg::TOL_W-1:0]      tol_ff;
   ibms_pkg::entry_type             qry_ff;
   logic                            rd_vld_ff;
   logic [ibms_pkg::IDX_W-1:0]      rd_idx_ff;
   logic                            sc_vld_ff;
   logic [ibms_pkg::SCORE_W-1:0]    sc_ff;
   logic [ibms_pkg::IDX_W-1:0]      sc_idx_ff;
   logic [ibms_pkg::SCORE_W-1:0]    best_ff;
   logic [ibms_pkg::IDX_W-1:0]      best_idx_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_found_ff;
   logic [ibms_pkg::INDEX_W-1:0]    rsp_index_ff;
   logic [ibms_pkg::SCORE_W-1:0]    rsp_score_ff;

   logic                            ram_we;
   logic [$bits(ibms_pkg::entry_type)-1:0] ram_rdata;
   ibms_pkg::entry_type             ent_rd;
   logic                            issue;
   logic                            qry_load;
   logic                            rsp_load;
   logic [ibms_pkg::SCORE_W-1:0]    pair_sc;

   // relation and bonus score of one stored entry against the query
   function automatic logic [ibms_pkg::SCORE_W-1:0] pair_score(
      input ibms_pkg::entry_type      q,
      input ibms_pkg::entry_type      e,
      input logic [ibms_pkg::TOL_W-1:0] tol
   );
      logic [ibms_pkg::SUM_W-1:0]   q_hi_tol;
      logic [ibms_pkg::SUM_W-1:0]   e_hi_tol;
      logic                         disjoint;
      logic                         exact;
      logic                         covered;
      logic                         covering;
      logic                         tag_hit;
      logic [ibms_pkg::SCORE_W-1:0] rel;
      logic [ibms_pkg::SCORE_W-1:0] bonus;
      q_hi_tol = {1'b0, q.hi} + ibms_pkg::SUM_W'(tol);
      e_hi_tol = {1'b0, e.hi} + ibms_pkg::SUM_W'(tol);
      disjoint = ({1'b0, e.lo} > q_hi_tol) || ({1'b0, q.lo} > e_hi_tol);
      exact    = (q.lo == e.lo) && (q.hi == e.hi);
      covered  = ((e.lo <= q.lo) && (e.hi > q.hi)) || ((e.lo < q.lo) && (e.hi >= q.hi));
      covering = ((q.lo <= e.lo) && (q.hi > e.hi)) || ((q.lo < e.lo) && (q.hi >= e.hi));
      tag_hit  = (q.tag == e.tag) || (q.tag[23:8] == ibms_pkg::BO_PREFIX) ||
                 (e.tag[23:8] == ibms_pkg::BO_PREFIX);
      if (exact) begin
         rel = ibms_pkg::REL_EXACT;
      end else if (covered) begin
         rel = ibms_pkg::REL_COVRD;
      end else if (covering) begin
         rel = ibms_pkg::REL_COVER;
      end else begin
         rel = ibms_pkg::REL_OVLP;
      end
      bonus = (tag_hit ? ibms_pkg::BONUS_TAG : '0) +
              ((q.zyg == e.zyg) ? ibms_pkg::BONUS_ZYG : '0);
      if (disjoint || (q.chrom != e.chrom)) begin
         pair_score = '0;
      end else begin
         pair_score = rel + bonus;
      end
   endfunction

   // reference table
   ibms_ram #(
      .WIDTH ($bits(ibms_pkg::entry_type)),
      .DEPTH (ibms_pkg::TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[ibms_pkg::IDX_W-1:0]),
      .wdata (q_head.cmd.ent),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign ent_rd  = ibms_pkg::entry_type'(ram_rdata);
   assign pair_sc = pair_score(qry_ff, ent_rd, tol_ff);

   // command sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      addr_in  = addr_ff;
      q_pop    = 1'b0;
      ram_we   = 1'b0;
      issue    = 1'b0;
      qry_load = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ibms_pkg::ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               unique case (q_head.cmd.kind)
                  ibms_pkg::CMD_LOAD: begin
                     if (count_ff < ibms_pkg::COUNT_W'(ibms_pkg::TABLE_DEPTH)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ibms_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  ibms_pkg::CMD_QUERY: begin
                     qry_load = 1'b1;
                     addr_in  = '0;
                     state_in = (count_ff == '0) ? ibms_pkg::ST_FINISH : ibms_pkg::ST_SCAN;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ibms_pkg::ST_SCAN: begin
            issue = 1'b1;
            if ((ibms_pkg::COUNT_W'(addr_ff) + 1'b1) == count_ff) begin
               state_in = ibms_pkg::ST_FINISH;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ibms_pkg::ST_FINISH: begin
            if (!rd_vld_ff && !sc_vld_ff && (!rsp_valid_ff || rsp_tready)) begin
               rsp_load = 1'b1;
               state_in = ibms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ibms_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ibms_pkg::ST_IDLE;
         count_ff     <= '0;
         tol_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         sc_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= issue;
         sc_vld_ff <= rd_vld_ff;
         if (csr_we) begin
            tol_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan address, query copy and scoring pipeline
   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      rd_idx_ff <= addr_ff;
      sc_ff     <= pair_sc;
      sc_idx_ff <= rd_idx_ff;
      if (qry_load) begin
         qry_ff <= q_head.cmd.ent;
      end
   end

   // running best, first strictly higher score wins
   always_ff @(posedge clock) begin
      if (qry_load) begin
         best_ff     <= '0;
         best_idx_ff <= '0;
      end else if (sc_vld_ff && (sc_ff > best_ff)) begin
         best_ff     <= sc_ff;
         best_idx_ff <= sc_idx_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= best_ff != '0;
         rsp_index_ff <= ibms_pkg::INDEX_W'(best_idx_ff);
         rsp_score_ff <= best_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_score_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

### sv/interval_best_match_scorer_top.sv
// Interval best-match scorer: a table of reference intervals, scanned once per query item.
// A load or clear item is done in the back end's idle state; a query runs through the
// one-entry-per-cycle scan of the table ram (skipped when empty) plus two scoring stages
// and the result, longer while a previous result waits for rsp_tready.
// Up to 2 items wait in the command queue, so input is taken while the back end is busy.
// Sync active-high reset clears entry count, queue, result and tolerance, not the table ram.
`timescale 1ns / 1ps
module interval_best_match_scorer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ibms_pkg::TOL_W-1:0]       csr_wdata,      // position_tolerance
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // chrom_id[7:0], pos_a[39:8], pos_b[71:40], type_tag[95:72], zyg_code[99:96], zero pad
   input  logic [ibms_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [ibms_pkg::OP_W-1:0]        req_tuser,      // op[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ibms_pkg::RSP_DATA_W-1:0]  rsp_tdata,      // match_index[9:0], score[15:10]
   output logic [ibms_pkg::RSP_USER_W-1:0]  rsp_tuser       // found[0]
);

   logic                     q_ready;
   logic                     q_push;
   logic                     q_pop;
   ibms_pkg::cmd_type        q_cmd;
   ibms_pkg::queue_head_type q_head;

   // item intake and op decode
   ibms_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   // decoupling queue
   ibms_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .ready    (q_ready),
      .pop      (q_pop),
      .head     (q_head)
   );

   // table, scan and result
   ibms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### dv/tb.sv
// self-checking testbench for the interval best-match scorer
`timescale 1ns / 1ps
module tb;
   import ibms_pkg::*;

   localparam int     RANDOM_ITEMS = 580;
   localparam int     SEGMENTS     = 6;
   localparam int     MAX_FILL     = 48;       // table kept small in the random part
   localparam int     DRAIN_CYCLES = 16;       // queued loads and clears finish well inside this
   localparam int     TIMEOUT_NS   = 2_000_000;
   localparam longint POS_MAX      = 64'h0000_0000_FFFF_FFFF;

   localparam bit [OP_W-1:0]    OP_UNKNOWN = 2'd3;
   localparam bit [CHROM_W-1:0] FILL_CHROM = 8'd1;
   localparam bit [TAG_W-1:0]   TAG_DEL    = "DEL";
   localparam bit [TAG_W-1:0]   TAG_DUP    = "DUP";
   localparam bit [TAG_W-1:0]   TAG_INV    = "INV";
   localparam bit [TAG_W-1:0]   TAG_INS    = "INS";
   localparam bit [TAG_W-1:0]   TAG_BON    = "Bon";

   typedef struct {
      bit [OP_W-1:0]    op;
      bit [CHROM_W-1:0] chrom;
      bit [POS_W-1:0]   pos_a;
      bit [POS_W-1:0]   pos_b;
      bit [TAG_W-1:0]   tag;
      bit [ZYG_W-1:0]   zyg;
   } interval_item_t;

   typedef struct {
      bit               found;
      bit [INDEX_W-1:0] idx;
      bit [SCORE_W-1:0] score;
   } match_t;

   // mirror of the reference table, predicts the best match of each query item
   class best_match_board;
      bit [CHROM_W-1:0] chrom_tab [TABLE_DEPTH];
      bit [POS_W-1:0]   pa_tab    [TABLE_DEPTH];
      bit [POS_W-1:0]   pb_tab    [TABLE_DEPTH];
      bit [TAG_W-1:0]   tag_tab   [TABLE_DEPTH];
      bit [ZYG_W-1:0]   zyg_tab   [TABLE_DEPTH];
      int unsigned      stored;
      bit [TOL_W-1:0]   tolerance;
      match_t           pending_matches [$];
      int unsigned      failures;

      // score of table entry k against the query item
      function bit [SCORE_W-1:0] score_entry(interval_item_t q, int k);
         bit [SUM_W-1:0]   q_lo, q_hi, e_lo, e_hi;
         bit [SCORE_W-1:0] bonus, rel;
         q_lo = (q.pos_a < q.pos_b) ? q.pos_a : q.pos_b;
         q_hi = (q.pos_a < q.pos_b) ? q.pos_b : q.pos_a;
         e_lo = (pa_tab[k] < pb_tab[k]) ? pa_tab[k] : pb_tab[k];
         e_hi = (pa_tab[k] < pb_tab[k]) ? pb_tab[k] : pa_tab[k];
         bonus = '0;
         if (q.tag == tag_tab[k] || q.tag[TAG_W-1:8] == BO_PREFIX ||
             tag_tab[k][TAG_W-1:8] == BO_PREFIX) begin
            bonus += BONUS_TAG;
         end
         if (q.zyg == zyg_tab[k]) begin
            bonus += BONUS_ZYG;
         end
         // disjoint test uses the slack, 33-bit sums so nothing wraps
         if (e_lo > q_hi + tolerance || q_lo > e_hi + tolerance) begin
            return '0;
         end
         if (q_lo == e_lo && q_hi == e_hi) begin
            rel = REL_EXACT;
         end else if ((e_lo <= q_lo && e_hi > q_hi) || (e_lo < q_lo && e_hi >= q_hi)) begin
            rel = REL_COVRD;
         end else if ((q_lo <= e_lo && q_hi > e_hi) || (q_lo < e_lo && q_hi >= e_hi)) begin
            rel = REL_COVER;
         end else begin
            rel = REL_OVLP;
         end
         return rel + bonus;
      endfunction

      // update the table for an accepted item, queue the expected match of a query
      function void note_item(interval_item_t it);
         bit [SCORE_W-1:0] best, pts;
         bit [INDEX_W-1:0] best_at;
         match_t           m;
         case (it.op)
            OP_LOAD: begin
               if (stored < TABLE_DEPTH) begin
                  chrom_tab[stored] = it.chrom;
                  pa_tab[stored]    = it.pos_a;
                  pb_tab[stored]    = it.pos_b;
                  tag_tab[stored]   = it.tag;
                  zyg_tab[stored]   = it.zyg;
                  stored++;
               end
            end
            OP_CLEAR: stored = 0;
            OP_QUERY: begin
               best    = '0;
               best_at = '0;
               for (int k = 0; k < stored; k++) begin
                  if (chrom_tab[k] == it.chrom) begin
                     pts = score_entry(it, k);
                     // first entry wins a tie
                     if (pts > best) begin
                        best    = pts;
                        best_at = INDEX_W'(k);
                     end
                  end
               end
               m.found = (best != '0);
               m.idx   = best_at;
               m.score = best;
               pending_matches = {pending_matches, m};
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         $display("tb: mismatch at %0t ns: %s", $time, what);
         failures++;
      endtask

      // compare one result item with the oldest expected match
      task check_match(logic found, logic [INDEX_W-1:0] idx, logic [SCORE_W-1:0] pts);
         match_t want;
         if (pending_matches.size() == 0) begin
            report("result item with no query waiting");
            return;
         end
         want = pending_matches.pop_front();
         if (found !== want.found) begin
            report($sformatf("found %b, expected %b", found, want.found));
         end
         if (idx !== want.idx) begin
            report($sformatf("match_index %0d, expected %0d", idx, want.idx));
         end
         if (pts !== want.score) begin
            report($sformatf("score %0d, expected %0d", pts, want.score));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [TOL_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   best_match_board board = new();
   bit              steady_flow = 1'b0;
   int unsigned     counted_items;

   interval_best_match_scorer_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver stalls now and then, never during the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= 12);
   end

   // check every accepted result item
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_match(rsp_tuser[0], rsp_tdata[INDEX_W-1:0],
                           rsp_tdata[INDEX_W+SCORE_W-1:INDEX_W]);
      end
   end

   function automatic interval_item_t make_item(bit [OP_W-1:0] op, bit [CHROM_W-1:0] chrom,
                                                bit [POS_W-1:0] pos_a, bit [POS_W-1:0] pos_b,
                                                bit [TAG_W-1:0] tag, bit [ZYG_W-1:0] zyg);
      interval_item_t it;
      it.op    = op;
      it.chrom = chrom;
      it.pos_a = pos_a;
      it.pos_b = pos_b;
      it.tag   = tag;
      it.zyg   = zyg;
      return it;
   endfunction

   function automatic bit [POS_W-1:0] clamp_pos(longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > POS_MAX) begin
         return '1;
      end
      return v[POS_W-1:0];
   endfunction

   // positions that stand in the chosen relation to [lo, hi]
   function automatic void shape_pair(input bit [POS_W-1:0] lo, input bit [POS_W-1:0] hi,
                                      input int kind, input bit [TOL_W-1:0] tol,
                                      output bit [POS_W-1:0] a, output bit [POS_W-1:0] b);
      longint l, h, w, d, s, e;
      l = lo;
      h = hi;
      w = h - l + 1;
      case (kind)
         // same interval
         0: begin
            s = l;
            e = h;
         end
         // wider on the right, same or wider on the left
         1: begin
            d = $urandom_range(0, 40);
            s = l - d;
            d = $urandom_range(1, 40);
            e = h + d;
         end
         // inside
         2: begin
            d = $urandom_range(0, 32'(w / 3));
            s = l + d;
            d = $urandom_range(0, 32'(w / 3));
            e = h - d;
         end
         // shifted right, partial overlap or just adjacent
         3: begin
            d = $urandom_range(1, 32'(w));
            s = l + d;
            e = h + d;
         end
         // gap after, around the slack
         4: begin
            d = $urandom_range(1, tol + 20);
            s = h + d;
            d = $urandom_range(0, 300);
            e = s + d;
         end
         // gap before, around the slack
         5: begin
            d = $urandom_range(1, tol + 20);
            e = l - d;
            s = e - 300;
         end
         default: begin
            s = $urandom;
            e = $urandom;
         end
      endcase
      a = clamp_pos(s);
      b = clamp_pos(e);
      if ($urandom_range(1) == 1) begin
         {a, b} = {b, a};
      end
   endfunction

   function automatic bit [TAG_W-1:0] pick_tag();
      case ($urandom_range(7))
         0: return TAG_DEL;
         1: return TAG_DUP;
         2: return TAG_INV;
         3: return TAG_INS;
         4: return {BO_PREFIX, 8'($urandom)};
         5: return {BO_PREFIX[15:8], 16'($urandom)};
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic bit [ZYG_W-1:0] pick_zyg();
      return ($urandom_range(9) < 7) ? 4'($urandom_range(3)) : 4'($urandom);
   endfunction

   // offer one item, with random idle cycles in front, and record it once taken
   task automatic push_item(interval_item_t it);
      while (!steady_flow && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= REQ_DATA_W'({it.zyg, it.tag, it.pos_b, it.pos_a, it.chrom});
      do @(posedge clock); while (!req_tready);
      if (it.op == OP_QUERY || it.op == OP_CLEAR ||
          (it.op == OP_LOAD && board.stored < TABLE_DEPTH)) begin
         counted_items++;
      end
      board.note_item(it);
   endtask

   // hold off until all matches are back and queued loads or clears are done
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_tolerance(bit [TOL_W-1:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.tolerance = value;
   endtask

   task automatic directed_checks();
      // empty table, then an unknown op that must be dropped
      push_item(make_item(OP_QUERY, 8'd5, 32'd1000, 32'd2000, TAG_DEL, 4'd1));
      push_item(make_item(OP_UNKNOWN, 8'd5, 32'd1000, 32'd2000, TAG_DEL, 4'd1));
      // reference set on chromosome 5 plus extremes elsewhere
      push_item(make_item(OP_LOAD, 8'd5, 32'd1000, 32'd2000, TAG_DEL, 4'd1));
      push_item(make_item(OP_LOAD, 8'd5, 32'd2500, 32'd1500, TAG_DUP, 4'd2));
      push_item(make_item(OP_LOAD, 8'd5, 32'd500, 32'd3000, TAG_INS, 4'd3));
      push_item(make_item(OP_LOAD, 8'd5, 32'd1200, 32'd1800, TAG_BON, 4'd4));
      push_item(make_item(OP_LOAD, 8'd6, 32'd1000, 32'd2000, TAG_DEL, 4'd1));
      push_item(make_item(OP_LOAD, 8'd255, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 24'hFF_FFFF, 4'd15));
      push_item(make_item(OP_LOAD, 8'd0, 32'd0, 32'd0, 24'd0, 4'd0));
      // exact, entry with a bo tag, covered, miss and an unused chromosome
      push_item(make_item(OP_QUERY, 8'd5, 32'd1000, 32'd2000, TAG_DEL, 4'd1));
      push_item(make_item(OP_QUERY, 8'd5, 32'd2000, 32'd1000, TAG_INV, 4'd9));
      push_item(make_item(OP_QUERY, 8'd5, 32'd2100, 32'd2200, TAG_INV, 4'd7));
      push_item(make_item(OP_QUERY, 8'd5, 32'd4000, 32'd5000, TAG_DEL, 4'd1));
      push_item(make_item(OP_QUERY, 8'd7, 32'd1000, 32'd2000, TAG_DEL, 4'd1));
      // top of the range with a bo tag on the query side
      push_item(make_item(OP_QUERY, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          {BO_PREFIX, 8'h00}, 4'd15));
      push_item(make_item(OP_QUERY, 8'd0, 32'd0, 32'd0, 24'd0, 4'd0));
      // a gap inside the slack counts as plain overlap
      set_tolerance(24'd1000);
      push_item(make_item(OP_QUERY, 8'd5, 32'd4000, 32'd3500, TAG_INV, 4'd3));
      // widest slack near the top, the sum must not wrap
      set_tolerance('1);
      push_item(make_item(OP_QUERY, 8'd255, 32'hFF00_0010, 32'hFF00_0000, 24'hFF_FFFF, 4'd0));
      // clear empties the table
      push_item(make_item(OP_CLEAR, 8'd5, '0, '0, '0, '0));
      push_item(make_item(OP_QUERY, 8'd5, 32'd1000, 32'd2000, TAG_DEL, 4'd1));
   endtask

   // fill the whole table, overflow it, and hit the last and an inner entry
   task automatic fill_table_checks();
      bit [POS_W-1:0] last_lo;
      last_lo = (TABLE_DEPTH - 1) * 16;
      set_tolerance('0);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         push_item(make_item(OP_LOAD, FILL_CHROM, k * 16, k * 16 + 8,
                             (k == TABLE_DEPTH - 1) ? TAG_DEL : TAG_DUP, 4'd0));
      end
      // table full, these would outscore the last entry if stored
      repeat (3) push_item(make_item(OP_LOAD, FILL_CHROM, last_lo, last_lo + 8, TAG_INV, 4'd5));
      push_item(make_item(OP_QUERY, FILL_CHROM, last_lo + 8, last_lo, TAG_INV, 4'd5));
      push_item(make_item(OP_QUERY, FILL_CHROM, 682 * 16 + 8, 682 * 16, TAG_DUP, 4'd0));
      push_item(make_item(OP_QUERY, FILL_CHROM, '0, '1, TAG_INV, 4'd9));
      push_item(make_item(OP_CLEAR, FILL_CHROM, '0, '0, '0, '0));
   endtask

   // a run of loads around one interval followed by queries near it, or a bit of noise
   task automatic random_burst();
      bit [CHROM_W-1:0] chr;
      bit [POS_W-1:0]   lo, hi, a, b;
      int unsigned      n;
      if ($urandom_range(99) < 15) begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            push_item(make_item(2'($urandom), 8'($urandom), $urandom, $urandom,
                                24'($urandom), 4'($urandom)));
         end
         return;
      end
      if (board.stored + 8 > MAX_FILL || $urandom_range(7) == 0) begin
         push_item(make_item(OP_CLEAR, 8'($urandom), $urandom, $urandom,
                             24'($urandom), 4'($urandom)));
      end
      chr = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      case ($urandom_range(3))
         0: lo = $urandom_range(1000);
         1: lo = POS_W'(POS_MAX - $urandom_range(5000));
         default: lo = $urandom;
      endcase
      hi = clamp_pos(longint'(lo) + $urandom_range(1, 3000));
      n = $urandom_range(1, 8);
      repeat (n) begin
         shape_pair(lo, hi, $urandom_range(6), board.tolerance, a, b);
         push_item(make_item(OP_LOAD, ($urandom_range(4) == 0) ? 8'($urandom_range(3)) : chr,
                             a, b, pick_tag(), pick_zyg()));
      end
      n = $urandom_range(1, 3);
      repeat (n) begin
         shape_pair(lo, hi, ($urandom_range(2) == 0) ? $urandom_range(6) : 0,
                    board.tolerance, a, b);
         push_item(make_item(OP_QUERY, chr, a, b, pick_tag(), pick_zyg()));
      end
      // sender waits for every match now and then
      if ($urandom_range(24) == 0) begin
         drain_results();
      end
   endtask

   // main sequence
   initial begin
      bit [TOL_W-1:0] tol_pick;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_tolerance('0);
      directed_checks();
      fill_table_checks();
      counted_items = 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: tol_pick = '0;
            1: tol_pick = TOL_W'($urandom_range(1, 64));
            2: tol_pick = '1;
            3: tol_pick = TOL_W'($urandom);
            4: tol_pick = TOL_W'($urandom_range(100, 5000));
            default: tol_pick = '0;
         endcase
         set_tolerance(tol_pick);
         steady_flow <= (seg == 1);
         while (counted_items < (seg + 1) * RANDOM_ITEMS / SEGMENTS) random_burst();
      end
      steady_flow <= 1'b0;
      drain_results();
      if (board.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule

### files.f
sv/ibms_pkg.sv
sv/ibms_ram.sv
sv/ibms_front.sv
sv/ibms_cmd_queue.sv
sv/ibms_back.sv
sv/interval_best_match_scorer_top.sv
dv/tb.sv
